// File: src/cmbi_pkg.sv
// ----------------------------------------------------------------------------
// cmbi_pkg: shared constants and helpers for the color matrix inverter
// fixed xyz primaries matrix, adjugate index table, rounding and saturation
// ----------------------------------------------------------------------------
package cmbi_pkg;

    localparam int unsigned N_ENT   = 9;
    localparam int unsigned W_ENT   = 32;
    localparam int unsigned W_GAIN  = 28;
    localparam int unsigned W_WGT   = 25;
    localparam int unsigned N_DIV   = 32;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    localparam logic [1:0] CFG_BLEND = 2'd0;
    localparam logic [1:0] CFG_RED   = 2'd1;
    localparam logic [1:0] CFG_GREEN = 2'd2;
    localparam logic [1:0] CFG_BLUE  = 2'd3;

    // srgb to xyz (d50) in q0.24, row major
    localparam logic [23:0] K_MAT [0:8] = '{
        24'd7316544, 24'd6460906, 24'd2400820,
        24'd3732931, 24'd12027586, 24'd1016699,
        24'd233203, 24'd1629068, 24'd11982288
    };

    // adj[e] = a[i0]*a[i1] - a[i2]*a[i3], flat row-major indexes
    localparam logic [3:0] ADJ_IDX [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // round x / 2^24 to nearest, ties away from zero
    function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] m;
        mag = x[63] ? 64'(-x) : 64'(x);
        m   = (mag + 64'h80_0000) >> 24;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

// File: src/color_matrix_blend_invert.sv
// ----------------------------------------------------------------------------
// color_matrix_blend_invert: blended, corrected and inverted 3x3 color matrix
// blends with identity, applies primaries and white balance, inverts
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one 3x3 matrix per item, m00..m22 in tdata, 32 bits
//   each, q8.24, m00 in the lowest bits. master stream gives the inverse,
//   r00..r22 in tdata in the same order, and the singular flag in tuser.
//   configuration writes (blend weight, three gains) go through a plain
//   write port and are made while no item is in flight.
//   the pipeline runs multiply and adjugate/determinant stages, then a
//   restoring divider with one quotient bit per stage (nine entries in
//   parallel), then a rounding and output register.
//   throughput is one item per cycle; a new item is taken every cycle that
//   the output register is empty or being read.
//   when the receiver stalls, the whole pipeline holds and o_s_axis_tready
//   drops; nothing is lost or repeated.
//   reset empties the pipeline and sets weight and gains to 1.0.
// ----------------------------------------------------------------------------
module color_matrix_blend_invert (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [287:0] i_s_axis_tdata,   // m00, m01, m02, m10 .. m22
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [287:0] o_m_axis_tdata,   // r00, r01, r02, r10 .. r22
    output logic         o_m_axis_tuser,   // singular
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [27:0]  i_cfg_wdata
);

    localparam int unsigned NSTG = 13 + cmbi_pkg::N_DIV + 1;

    logic [cmbi_pkg::W_WGT-1:0]  r_wgt;
    logic [cmbi_pkg::W_GAIN-1:0] r_gain [0:2];
    logic [NSTG-1:0]             r_vld;
    logic                        en;
    logic                        accept;

    assign en              = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wgt  <= cmbi_pkg::W_WGT'(cmbi_pkg::ONE_Q24);
            r_gain <= '{default: cmbi_pkg::W_GAIN'(cmbi_pkg::ONE_Q24)};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cmbi_pkg::CFG_BLEND: r_wgt     <= i_cfg_wdata[cmbi_pkg::W_WGT-1:0];
                cmbi_pkg::CFG_RED:   r_gain[0] <= i_cfg_wdata;
                cmbi_pkg::CFG_GREEN: r_gain[1] <= i_cfg_wdata;
                cmbi_pkg::CFG_BLUE:  r_gain[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    // front stages
    logic signed [57:0]  r1_pw  [0:8];
    logic signed [31:0]  r2_t   [0:8];
    logic signed [57:0]  r3_kp  [0:8][0:2];
    logic signed [31:0]  r4_c   [0:8];
    logic signed [60:0]  r5_cg  [0:8];
    logic signed [31:0]  r6_a   [0:8];
    logic signed [63:0]  r7_p0  [0:8];
    logic signed [63:0]  r7_p1  [0:8];
    logic signed [31:0]  r7_a0  [0:2];
    logic signed [63:0]  r8_adj [0:8];
    logic signed [31:0]  r8_a0  [0:2];
    logic signed [64:0]  r9_pl  [0:2];
    logic signed [63:0]  r9_ph  [0:2];
    logic signed [63:0]  r9_adj [0:8];
    logic signed [97:0]  r10_p  [0:2];
    logic signed [63:0]  r10_adj[0:8];
    logic signed [97:0]  r11_det;
    logic signed [63:0]  r11_adj[0:8];
    logic [96:0]         r12_dm;
    logic                r12_dneg;
    logic [63:0]         r12_am [0:8];
    logic [8:0]          r12_aneg;

    // divider stages, index 0 is the divider entry
    logic [111:0]        r_rem  [0:cmbi_pkg::N_DIV][0:8];
    logic [31:0]         r_q    [0:cmbi_pkg::N_DIV][0:8];
    logic [96:0]         r_dm   [0:cmbi_pkg::N_DIV];
    logic [8:0]          r_neg  [0:cmbi_pkg::N_DIV];
    logic [8:0]          r_ovf  [0:cmbi_pkg::N_DIV];
    logic                r_sing [0:cmbi_pkg::N_DIV];

    logic [287:0]        r_out_data;
    logic                r_out_sing;

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [63:0] s;
            logic signed [25:0] diag;
            diag = 26'sh100_0000 - $signed({1'b0, r_wgt});
            for (int e = 0; e < 9; e++) begin
                r1_pw[e] <= $signed(i_s_axis_tdata[32*e +: 32]) * $signed({1'b0, r_wgt});
                s = cmbi_pkg::rnd24(64'(r1_pw[e]));
                if (e % 4 == 0) s = s + 64'(diag);
                r2_t[e] <= cmbi_pkg::sat32(s);
            end
            for (int e = 0; e < 9; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r3_kp[e][k] <= $signed({1'b0, cmbi_pkg::K_MAT[(e/3)*3 + k]})
                                   * r2_t[k*3 + e%3];
                end
                s = 64'(r3_kp[e][0]) + 64'(r3_kp[e][1]) + 64'(r3_kp[e][2]);
                r4_c[e]  <= cmbi_pkg::sat32(cmbi_pkg::rnd24(s));
                r5_cg[e] <= r4_c[e] * $signed({1'b0, r_gain[e%3]});
                r6_a[e]  <= cmbi_pkg::sat32(cmbi_pkg::rnd24(64'(r5_cg[e])));
                r7_p0[e] <= r6_a[cmbi_pkg::ADJ_IDX[e][0]] * r6_a[cmbi_pkg::ADJ_IDX[e][1]];
                r7_p1[e] <= r6_a[cmbi_pkg::ADJ_IDX[e][2]] * r6_a[cmbi_pkg::ADJ_IDX[e][3]];
                r8_adj[e]  <= r7_p0[e] - r7_p1[e];
                r9_adj[e]  <= r8_adj[e];
                r10_adj[e] <= r9_adj[e];
                r11_adj[e] <= r10_adj[e];
                r12_aneg[e] <= r11_adj[e][63];
                r12_am[e]   <= r11_adj[e][63] ? 64'(-r11_adj[e]) : 64'(r11_adj[e]);
            end
            // determinant along the first row, adj split in 32-bit halves
            for (int k = 0; k < 3; k++) begin
                r7_a0[k] <= r6_a[k];
                r8_a0[k] <= r7_a0[k];
                r9_pl[k] <= $signed({1'b0, r8_adj[k*3][31:0]}) * r8_a0[k];
                r9_ph[k] <= $signed(r8_adj[k*3][63:32]) * r8_a0[k];
                r10_p[k] <= (98'(r9_ph[k]) <<< 32) + 98'(r9_pl[k]);
            end
            r11_det  <= r10_p[0] + r10_p[1] + r10_p[2];
            r12_dneg <= r11_det[97];
            r12_dm   <= r11_det[97] ? 97'(-r11_det) : 97'(r11_det);
            // divider entry: quotient of 2^32 or more saturates anyway
            r_dm[0]   <= r12_dm;
            r_sing[0] <= ~|r12_dm[96:42];
            for (int e = 0; e < 9; e++) begin
                r_rem[0][e] <= {r12_am[e], 48'd0};
                r_q[0][e]   <= '0;
                r_neg[0][e] <= r12_aneg[e] ^ r12_dneg;
                r_ovf[0][e] <= {17'd0, r12_am[e], 48'd0} >= {r12_dm, 32'd0};
            end
        end
    end

    for (genvar d = 0; d < cmbi_pkg::N_DIV; d++) begin : g_div
        localparam int unsigned SH = cmbi_pkg::N_DIV - 1 - d;
        always_ff @(posedge i_clk) begin
            if (en) begin
                logic [127:0] sub;
                logic [127:0] dif;
                sub = {31'd0, r_dm[d]} << SH;
                r_dm[d+1]   <= r_dm[d];
                r_sing[d+1] <= r_sing[d];
                r_neg[d+1]  <= r_neg[d];
                r_ovf[d+1]  <= r_ovf[d];
                for (int e = 0; e < 9; e++) begin
                    dif = {16'd0, r_rem[d][e]} - sub;
                    if ({16'd0, r_rem[d][e]} >= sub) begin
                        r_rem[d+1][e] <= dif[111:0];
                        r_q[d+1][e]   <= r_q[d][e] | (32'd1 << SH);
                    end else begin
                        r_rem[d+1][e] <= r_rem[d][e];
                        r_q[d+1][e]   <= r_q[d][e];
                    end
                end
            end
        end
    end

    // final rounding and saturation
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [32:0] qf;
            for (int e = 0; e < 9; e++) begin
                qf = {1'b0, r_q[cmbi_pkg::N_DIV][e]}
                   + 33'({r_rem[cmbi_pkg::N_DIV][e], 1'b0} >= {16'd0, r_dm[cmbi_pkg::N_DIV]});
                if (r_ovf[cmbi_pkg::N_DIV][e]) qf = 33'h1_0000_0000;
                if (r_sing[cmbi_pkg::N_DIV]) begin
                    r_out_data[32*e +: 32] <= (e % 4 == 0) ? cmbi_pkg::ONE_Q24 : 32'd0;
                end else if (r_neg[cmbi_pkg::N_DIV][e]) begin
                    r_out_data[32*e +: 32] <= (qf > 33'h0_8000_0000) ? 32'h8000_0000
                                                                      : 32'(-qf);
                end else begin
                    r_out_data[32*e +: 32] <= (qf > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                      : qf[31:0];
                end
            end
            r_out_sing <= r_sing[cmbi_pkg::N_DIV];
        end
    end

    assign o_m_axis_tdata = r_out_data;
    assign o_m_axis_tuser = r_out_sing;

`ifndef NO_ASSERTIONS
    a_sing_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tdata[31:0] == cmbi_pkg::ONE_Q24 && o_m_axis_tdata[63:32] == 32'd0
            && o_m_axis_tdata[159:128] == cmbi_pkg::ONE_Q24
            && o_m_axis_tdata[287:256] == cmbi_pkg::ONE_Q24)
        else $error("singular result is not the identity");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");
`endif

endmodule
